// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/tdut_pkg.sv
`default_nettype none

package tdut_pkg;

  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 16;
  localparam int RX_WAIT_W   = 17;
  localparam int BITS_W      = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_OUT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_IN    = 3'd4;

  localparam logic [CNT_W-1:0]  PRESCALE_RST  = 16'd1;
  localparam logic [CNT_W-1:0]  BIT_PER_RST   = 16'd16;
  localparam logic [BITS_W-1:0] TX_BITS       = 4'd10;
  localparam logic [BITS_W-1:0] RX_BITS       = 4'd9;
  localparam logic [BITS_W-1:0] RX_LAST       = 4'd1;

  typedef struct packed {
    logic             enable;
    logic [CNT_W-1:0] prescale_count;
    logic [CNT_W-1:0] bit_period;
    logic             invert_out;
    logic             invert_in;
  } tdut_cfg_t;

  typedef struct packed {
    logic              send_ready;
    logic [BYTE_W-1:0] send_byte;
    logic              line_in;
  } tdut_in_item_t;

  typedef struct packed {
    logic              line_out;
    logic              send_taken;
    logic              recv_valid;
    logic [BYTE_W-1:0] recv_byte;
  } tdut_out_item_t;

  typedef struct packed {
    logic line_out;
    logic send_taken;
  } tdut_tx_res_t;

  typedef struct packed {
    logic              recv_valid;
    logic [BYTE_W-1:0] recv_byte;
  } tdut_rx_res_t;

endpackage

`default_nettype wire

// File: hdl/tdut_ifs.sv
`default_nettype none

interface tdut_in_if;
  import tdut_pkg::*;
  logic              valid;
  logic              ready;
  logic              send_ready;
  logic [BYTE_W-1:0] send_byte;
  logic              line_in;

  modport source (output valid, output send_ready, output send_byte, output line_in,
                  input ready);
  modport sink (input valid, input send_ready, input send_byte, input line_in,
                output ready);
endinterface

interface tdut_out_if;
  import tdut_pkg::*;
  logic              valid;
  logic              ready;
  logic              line_out;
  logic              send_taken;
  logic              recv_valid;
  logic [BYTE_W-1:0] recv_byte;

  modport source (output valid, output line_out, output send_taken, output recv_valid,
                  output recv_byte, input ready);
  modport sink (input valid, input line_out, input send_taken, input recv_valid,
                input recv_byte, output ready);
endinterface

interface tdut_cfg_if;
  import tdut_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/tdut_tx.sv
`default_nettype none

module tdut_tx (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  tdut_pkg::tdut_cfg_t                 cfg,
  input  logic                                send_ready,
  input  logic [tdut_pkg::BYTE_W-1:0]         send_byte,
  output tdut_pkg::tdut_tx_res_t              res
);
  import tdut_pkg::*;

  logic [BITS_W-1:0] bits_r, bits_nxt;
  logic [BYTE_W-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]  wait_r, wait_nxt;
  logic              level_r, level_nxt;
  logic              taken;
  logic [CNT_W-1:0]  wait_dec;
  logic [BITS_W-1:0] bits_dec;

  always_comb begin
    bits_nxt  = bits_r;
    shift_nxt = shift_r;
    wait_nxt  = wait_r;
    level_nxt = level_r;
    taken     = 1'b0;
    wait_dec  = wait_r - 1'b1;
    bits_dec  = bits_r - 1'b1;
    if (step) begin
      if (bits_r == '0) begin
        if (send_ready) begin
          bits_nxt  = TX_BITS;
          shift_nxt = send_byte;
          wait_nxt  = cfg.bit_period;
          level_nxt = cfg.invert_out;
          taken     = 1'b1;
        end
      end else if (wait_dec == '0) begin
        level_nxt = shift_r[0] ^ cfg.invert_out;
        shift_nxt = {1'b1, shift_r[BYTE_W-1:1]};
        wait_nxt  = cfg.bit_period;
        bits_nxt  = bits_dec;
        if (bits_dec == '0) begin
          level_nxt = ~cfg.invert_out;
        end
      end else begin
        wait_nxt = wait_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r  <= '0;
      shift_r <= '0;
      wait_r  <= '0;
      level_r <= 1'b1;
    end else begin
      bits_r  <= bits_nxt;
      shift_r <= shift_nxt;
      wait_r  <= wait_nxt;
      level_r <= level_nxt;
    end
  end

  assign res.line_out   = level_nxt;
  assign res.send_taken = taken;

endmodule

`default_nettype wire

// File: hdl/tdut_rx.sv
`default_nettype none

module tdut_rx (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  tdut_pkg::tdut_cfg_t         cfg,
  input  logic                        line_in,
  output tdut_pkg::tdut_rx_res_t      res
);
  import tdut_pkg::*;

  logic [BITS_W-1:0]    bits_r, bits_nxt;
  logic [BYTE_W-1:0]    shift_r, shift_nxt;
  logic [RX_WAIT_W-1:0] wait_r, wait_nxt;
  logic [RX_WAIT_W-1:0] wait_dec;
  logic [BITS_W-1:0]    bits_dec;
  logic                 sensed;
  logic                 valid;

  always_comb begin
    bits_nxt  = bits_r;
    shift_nxt = shift_r;
    wait_nxt  = wait_r;
    valid     = 1'b0;
    sensed    = line_in ^ cfg.invert_in;
    wait_dec  = wait_r - 1'b1;
    bits_dec  = bits_r - 1'b1;
    if (step) begin
      if (bits_r == '0) begin
        if (!sensed) begin
          bits_nxt  = RX_BITS;
          shift_nxt = '0;
          wait_nxt  = {1'b0, cfg.bit_period} + {2'b00, cfg.bit_period[CNT_W-1:1]};
        end
      end else if (wait_dec == '0) begin
        shift_nxt = {sensed, shift_r[BYTE_W-1:1]};
        wait_nxt  = {1'b0, cfg.bit_period};
        bits_nxt  = bits_dec;
        valid     = (bits_dec == RX_LAST);
      end else begin
        wait_nxt = wait_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r  <= '0;
      shift_r <= '0;
      wait_r  <= '0;
    end else begin
      bits_r  <= bits_nxt;
      shift_r <= shift_nxt;
      wait_r  <= wait_nxt;
    end
  end

  assign res.recv_valid = valid;
  assign res.recv_byte  = valid ? shift_nxt : '0;

endmodule

`default_nettype wire

// File: hdl/tick_driven_uart_transceiver_top.sv
// Pipeline: a request is registered at acceptance, and its result is registered in the
// result register when it advances. Throughput: one request per cycle while out_if is
// not stalled; the transmit and receive channels update between the input register and the result register.
// Reset: synchronous active-low rst_n clears the pipeline, channel state and
// configuration (prescaler reload 1, bit period 16, line idles at mark).
`default_nettype none

module tick_driven_uart_transceiver_top (
  input  logic              clk,
  input  logic              rst_n,
  tdut_in_if.sink           in_if,
  tdut_out_if.source        out_if,
  tdut_cfg_if.sink          cfg_if
);
  import tdut_pkg::*;

  `include "assert_macros.svh"

  tdut_cfg_t      cfg_r;
  logic           s1_valid_r;
  tdut_in_item_t  s1_item_r;
  logic           out_valid_r;
  tdut_out_item_t out_item_r, out_item_nxt;
  logic [CNT_W-1:0] prescale_left_r, prescale_left_nxt;
  logic [CNT_W-1:0] prescale_dec;
  logic           adv;
  logic           step;
  tdut_tx_res_t   tx_res;
  tdut_rx_res_t   rx_res;

  assign adv          = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || adv;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable         <= 1'b0;
      cfg_r.prescale_count <= PRESCALE_RST;
      cfg_r.bit_period     <= BIT_PER_RST;
      cfg_r.invert_out     <= 1'b0;
      cfg_r.invert_in      <= 1'b0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_ENABLE:   cfg_r.enable         <= cfg_if.data[0];
        CFG_PRESCALE: cfg_r.prescale_count <= cfg_if.data;
        CFG_BIT_PER:  cfg_r.bit_period     <= cfg_if.data;
        CFG_INV_OUT:  cfg_r.invert_out     <= cfg_if.data[0];
        CFG_INV_IN:   cfg_r.invert_in      <= cfg_if.data[0];
        default: begin
        end
      endcase
    end
  end

  // prescaler: count down per advancing request while enabled, reload and step the channels on expiry
  always_comb begin
    prescale_dec      = prescale_left_r - 1'b1;
    prescale_left_nxt = prescale_left_r;
    step              = 1'b0;
    if (adv && cfg_r.enable) begin
      if (prescale_dec == '0) begin
        prescale_left_nxt = cfg_r.prescale_count;
        step              = 1'b1;
      end else begin
        prescale_left_nxt = prescale_dec;
      end
    end
  end

  tdut_tx u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .cfg        (cfg_r),
    .send_ready (s1_item_r.send_ready),
    .send_byte  (s1_item_r.send_byte),
    .res        (tx_res)
  );

  tdut_rx u_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .cfg     (cfg_r),
    .line_in (s1_item_r.line_in),
    .res     (rx_res)
  );

  always_comb begin
    out_item_nxt.line_out   = tx_res.line_out;
    out_item_nxt.send_taken = tx_res.send_taken;
    out_item_nxt.recv_valid = rx_res.recv_valid;
    out_item_nxt.recv_byte  = rx_res.recv_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      prescale_left_r <= PRESCALE_RST;
    end else begin
      prescale_left_r <= prescale_left_nxt;
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_item_r.send_ready <= in_if.send_ready;
      s1_item_r.send_byte  <= in_if.send_byte;
      s1_item_r.line_in    <= in_if.line_in;
    end
    if (adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.line_out   = out_item_r.line_out;
  assign out_if.send_taken = out_item_r.send_taken;
  assign out_if.recv_valid = out_item_r.recv_valid;
  assign out_if.recv_byte  = out_item_r.recv_byte;

  `ASSERT_NOW(a_taken_needs_offer, adv && tx_res.send_taken, s1_item_r.send_ready && cfg_r.enable, "byte taken without offer or while disabled")
  `ASSERT_NOW(a_recv_needs_step, rx_res.recv_valid, step && adv, "receive result outside a channel step")
  `ASSERT_NOW(a_recv_byte_clear, out_valid_r && !out_item_r.recv_valid, out_item_r.recv_byte == '0, "recv_byte not clear without recv_valid")
  `ASSERT_NEXT(a_frozen_when_off, !cfg_r.enable && !cfg_if.valid, prescale_left_r == $past(prescale_left_r), "prescaler moved while disabled")

endmodule

`default_nettype wire

// File: tb/tdut_checker.sv
module tdut_checker
  import tdut_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tdut_in_if          in_mon,
  tdut_out_if         out_mon,
  tdut_cfg_if         cfg_mon,
  output int unsigned errors,
  output int unsigned awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  tdut_cfg_t            regs;
  logic [CNT_W-1:0]     psc_cnt;
  logic [BITS_W-1:0]    tx_cnt;
  logic [BYTE_W-1:0]    tx_sr;
  logic [CNT_W-1:0]     tx_dly;
  logic                 tx_lvl;
  logic [BITS_W-1:0]    rx_cnt;
  logic [BYTE_W-1:0]    rx_sr;
  logic [RX_WAIT_W-1:0] rx_dly;
  tdut_out_item_t       tick_q[$];
  int unsigned          bad_cnt = 0;

  function automatic tdut_out_item_t advance_uart(input tdut_in_item_t req);
    tdut_out_item_t res;
    logic           taken;
    logic           got_byte;
    logic [7:0]     rx_val;
    taken    = 1'b0;
    got_byte = 1'b0;
    rx_val   = '0;
    if (regs.enable) begin
      psc_cnt = psc_cnt - 1'b1;
      if (psc_cnt == '0) begin
        psc_cnt = regs.prescale_count;
        if (tx_cnt == '0) begin
          if (req.send_ready) begin
            tx_cnt = TX_BITS;
            tx_sr  = req.send_byte;
            tx_dly = regs.bit_period;
            tx_lvl = regs.invert_out;
            taken  = 1'b1;
          end
        end else begin
          tx_dly = tx_dly - 1'b1;
          if (tx_dly == '0) begin
            tx_lvl = tx_sr[0] ^ regs.invert_out;
            tx_sr  = {1'b1, tx_sr[7:1]};
            tx_dly = regs.bit_period;
            tx_cnt = tx_cnt - 1'b1;
            if (tx_cnt == '0) tx_lvl = ~regs.invert_out;
          end
        end
        if (rx_cnt == '0) begin
          if (req.line_in == regs.invert_in) begin
            rx_cnt = RX_BITS;
            rx_sr  = '0;
            rx_dly = {1'b0, regs.bit_period} + {2'b00, regs.bit_period[15:1]};
          end
        end else begin
          rx_dly = rx_dly - 1'b1;
          if (rx_dly == '0) begin
            rx_sr  = {req.line_in == ~regs.invert_in, rx_sr[7:1]};
            rx_dly = {1'b0, regs.bit_period};
            rx_cnt = rx_cnt - 1'b1;
            if (rx_cnt == RX_LAST) begin
              got_byte = 1'b1;
              rx_val   = rx_sr;
            end
          end
        end
      end
    end
    res.line_out   = tx_lvl;
    res.send_taken = taken;
    res.recv_valid = got_byte;
    res.recv_byte  = rx_val;
    return res;
  endfunction

  always @(posedge clk) begin
    tdut_in_item_t  req;
    tdut_out_item_t got;
    tdut_out_item_t want;
    if (!rst_n) begin
      regs = '{enable: 1'b0, prescale_count: PRESCALE_RST, bit_period: BIT_PER_RST,
               invert_out: 1'b0, invert_in: 1'b0};
      psc_cnt = PRESCALE_RST;
      tx_cnt  = '0;
      tx_sr   = '0;
      tx_dly  = '0;
      tx_lvl  = 1'b1;
      rx_cnt  = '0;
      rx_sr   = '0;
      rx_dly  = '0;
      tick_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_ENABLE:   regs.enable         = cfg_mon.data[0];
          CFG_PRESCALE: regs.prescale_count = cfg_mon.data;
          CFG_BIT_PER:  regs.bit_period     = cfg_mon.data;
          CFG_INV_OUT:  regs.invert_out     = cfg_mon.data[0];
          CFG_INV_IN:   regs.invert_in      = cfg_mon.data[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        req.send_ready = in_mon.send_ready;
        req.send_byte  = in_mon.send_byte;
        req.line_in    = in_mon.line_in;
        tick_q.push_back(advance_uart(req));
      end
      if (out_mon.valid && out_mon.ready) begin
        got.line_out   = out_mon.line_out;
        got.send_taken = out_mon.send_taken;
        got.recv_valid = out_mon.recv_valid;
        got.recv_byte  = out_mon.recv_byte;
        if (tick_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("%0t: unexpected result line_out=%b taken=%b valid=%b byte=%02h",
                     $realtime, got.line_out, got.send_taken, got.recv_valid, got.recv_byte);
        end else begin
          want = tick_q.pop_front();
          if (got.line_out !== want.line_out || got.send_taken !== want.send_taken ||
              got.recv_valid !== want.recv_valid || got.recv_byte !== want.recv_byte) begin
            bad_cnt++;
            if (bad_cnt <= 10)
              $display("%0t: mismatch exp line_out=%b taken=%b valid=%b byte=%02h, got line_out=%b taken=%b valid=%b byte=%02h",
                       $realtime, want.line_out, want.send_taken, want.recv_valid,
                       want.recv_byte, got.line_out, got.send_taken, got.recv_valid,
                       got.recv_byte);
          end
        end
      end
    end
    errors   <= bad_cnt;
    awaiting <= tick_q.size();
  end

endmodule

// File: tb/tb_tick_driven_uart_transceiver_top.sv
module tb_tick_driven_uart_transceiver_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tdut_pkg::*;

  localparam int LIMIT          = 3_000_000;
  localparam int HOLD_CYCLES    = 300;
  localparam int N_PHASES       = 10;
  localparam int FIRST_LONG     = 7;
  localparam int PRESSURE_PHASE = 4;

  localparam bit PLAN_EN [N_PHASES] = '{1, 1, 1, 1, 1, 0, 1, 1, 1, 1};
  localparam int PLAN_P  [N_PHASES] = '{1, 1, 2, 3, 1, 1, 1, 1, 0, 65535};
  localparam int PLAN_B  [N_PHASES] = '{1, 4, 3, 2, 2, 2, 5, 0, 65535, 1};
  localparam bit PLAN_IO [N_PHASES] = '{0, 1, 0, 1, 0, 1, 1, 0, 1, 0};
  localparam bit PLAN_II [N_PHASES] = '{0, 0, 1, 1, 0, 0, 1, 1, 0, 0};
  localparam int PLAN_N  [N_PHASES] = '{80, 80, 80, 80, 80, 30, 80,
                                        60, 60, 60};

  localparam int IDLE_TX [4] = '{0, 52, 0, 24};
  localparam int IDLE_RX [4] = '{0, 0, 52, 24};

  localparam logic [19:0] DIR_LINE      = 20'b1000_0000_0010_1111_1111;
  localparam logic [7:0]  DIR_BYTES [4] = '{8'h00, 8'hFF, 8'hA5, 8'h5A};

  typedef struct {
    logic            lvl;
    longint unsigned run;
  } line_seg_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        hold_off = 1'b0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          cur_p = 1;
  int          cur_b = 16;
  logic        cur_ii = 1'b0;
  line_seg_t   line_q[$];
  line_seg_t   seg;
  longint unsigned seg_left = 0;
  int unsigned chk_errors;
  int unsigned chk_awaiting;

  tdut_in_if  in_ch();
  tdut_out_if out_ch();
  tdut_cfg_if cfg_ch();

  tick_driven_uart_transceiver_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  tdut_checker chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .cfg_mon  (cfg_ch),
    .errors   (chk_errors),
    .awaiting (chk_awaiting)
  );

  always #5ns clk = ~clk;

  function automatic logic next_line_in();
    longint unsigned bt;
    logic [7:0]      data_v;
    if (seg_left == 0) begin
      if (line_q.size() == 0) begin
        bt = longint'(cur_p == 0 ? 65536 : cur_p) * longint'(cur_b == 0 ? 65536 : cur_b);
        if ($urandom_range(9) < 8) begin
          data_v = $urandom_range(255);
          line_q.push_back('{lvl: 1'b1, run: 1 + $urandom_range(3) + bt * $urandom_range(2)});
          line_q.push_back('{lvl: 1'b0, run: bt});
          for (int k = 0; k < 8; k++) line_q.push_back('{lvl: data_v[k], run: bt});
          line_q.push_back('{lvl: 1'b1, run: bt * $urandom_range(1, 2)});
        end else begin
          repeat ($urandom_range(1, 8))
            line_q.push_back('{lvl: $urandom_range(1) != 0, run: 1 + $urandom_range(3)});
        end
      end
      seg = line_q.pop_front();
      seg_left = seg.run;
    end
    seg_left--;
    return seg.lvl ^ cur_ii;
  endfunction

  task automatic offer_tick(input tdut_in_item_t req);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.send_ready <= req.send_ready;
    in_ch.send_byte  <= req.send_byte;
    in_ch.line_in    <= req.line_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    tdut_in_item_t req;
    repeat (n) begin
      req.send_ready = $urandom_range(99) < 70;
      req.send_byte  = $urandom_range(255);
      req.line_in    = next_line_in();
      offer_tick(req);
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chk_awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input bit en, input int p, input int b, input bit io,
                               input bit ii);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    idx = '{CFG_ENABLE, CFG_PRESCALE, CFG_BIT_PER, CFG_INV_OUT, CFG_INV_IN};
    val = '{16'(en), 16'(p), 16'(b), 16'(io), 16'(ii)};
    for (int k = 0; k < 5; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data  <= val[k];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    cur_p  = p;
    cur_b  = b;
    cur_ii = ii;
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    tdut_in_item_t req;
    int            mode;
    in_ch.valid      <= 1'b0;
    in_ch.send_ready <= 1'b0;
    in_ch.send_byte  <= '0;
    in_ch.line_in    <= 1'b1;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_ENABLE;
    cfg_ch.data      <= '0;
    rst_n            <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // hold frozen: disabled after reset
    for (int k = 0; k < 3; k++) begin
      req = '{send_ready: 1'b1, send_byte: DIR_BYTES[k], line_in: k[0]};
      offer_tick(req);
    end
    settle();

    load_settings(1'b1, 1, 1, 1'b0, 1'b0);
    for (int k = 0; k < 20; k++) begin
      req = '{send_ready: (k % 3) != 2, send_byte: DIR_BYTES[k % 4],
              line_in: DIR_LINE[19-k]};
      offer_tick(req);
    end
    settle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      mode = (ph < FIRST_LONG) ? ph % 4 : 0;
      tx_idle_pct  = IDLE_TX[mode];
      rx_stall_pct = IDLE_RX[mode];
      load_settings(PLAN_EN[ph], PLAN_P[ph], PLAN_B[ph], PLAN_IO[ph], PLAN_II[ph]);
      if (ph == PRESSURE_PHASE) hold_off <= 1'b1;
      run_random(PLAN_N[ph]);
      settle();
    end

    if (chk_errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
